[sv/haversine_distance_top_defines.svh]
// ----------------------------------------------------------------------------
// haversine distance assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_TOP_DEFINES_SVH
`define HAVERSINE_DISTANCE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define HVD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hvd assertion failed");
`define HVD_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("hvd assertion failed");
`else
`define HVD_ASSERT(lbl, clk, rst_n, prop)
`define HVD_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[sv/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// haversine distance package
// fixed-point constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int TABLE_LEN = 32;
    // cordic datapath width, q30 values with headroom
    localparam int CW        = 34;
    // integer square root: one result bit per stage
    localparam int SQ_STEPS  = 31;
    localparam int SQ_NW     = 2 * SQ_STEPS;

    // round(2^62 / 3.6e9): 1e-7 degree units to binary angle
    localparam logic [30:0] CONV_K     = 31'd1281023894;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [31:0] GAIN_Q30   = 32'd652032874;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    // 2 * 6371 * 1024
    localparam logic [23:0] DIST_SCALE = 24'd13047808;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[sv/haversine_distance_top.sv]
// ----------------------------------------------------------------------------
// haversine distance top
// pipelined great-circle distance between two points, cordic based
// ----------------------------------------------------------------------------
// usage:
//  input channel: i_valid / o_stall carries one request of two points
//   (i_lat_a, i_lon_a, i_lat_b, i_lon_b) in 1e-7 degree units
//  output channel: o_valid / i_stall carries o_distance in 1/1024 km
//  a request is taken at a clock edge where valid is high and stall is low
//  throughput: one request per cycle while the output is not stalled
//  datapath: the two unrolled
//   cordic pipelines (rotation for sin/cos, vectoring for atan2) and the
//   31-stage integer square root, one result bit per stage
//  when the receiver stalls a full output register, the whole pipeline
//   holds and o_stall rises; nothing is dropped or repeated
//  reset (i_rst_n low, synchronous) clears every valid bit; payload
//   registers are not reset
//  no configuration, no state kept between requests
// ----------------------------------------------------------------------------
`include "haversine_distance_top_defines.svh"

module haversine_distance_top #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [24:0] o_distance
);
    import hvd_pkg::*;

    localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam logic signed [CW-1:0] LP_ONE = {{(CW-31){1'b0}}, ONE_Q30};

    logic w_en;

    // stage a: differences
    logic               r_a_vld;
    logic signed [30:0] r_lat_a, r_lat_b;
    logic signed [31:0] r_dlat;
    logic signed [32:0] r_dlon;

    // stage b: binary angles
    logic               r_b_vld;
    logic        [31:0] r_t [4];
    logic signed [62:0] w_pa, w_pb;
    logic signed [63:0] w_pl;
    logic signed [64:0] w_po;

    // stage c: quadrant and residual angle
    logic               r_c_vld;
    logic signed [CW-1:0] r_c_z [4];
    logic        [1:0]    r_c_q [4];

    // rotation cordic
    logic                 r_r_vld [NS];
    logic signed [CW-1:0] r_rx [4][NS];
    logic signed [CW-1:0] r_ry [4][NS];
    logic signed [CW-1:0] r_rz [4][NS];
    logic        [1:0]    r_rq [4][NS];

    // quadrant correction: ca, cb, sl, so
    logic                 r_qd_vld;
    logic signed [CW-1:0] r_qv [4];

    // products and h
    logic                   r_p1_vld, r_p2_vld, r_h_vld;
    logic signed [CW-1:0]   r_p_ll, r_p_ab, r_p_oo, r_p_ll2, r_p2;
    logic signed [2*CW-1:0] w_m_ll, w_m_ab, w_m_oo, w_m_2;
    logic signed [CW-1:0]   w_h;
    logic        [30:0]     r_h;

    // square roots: unit 0 is sqrt(h), unit 1 is sqrt(1-h)
    logic              r_s_vld [SQ_STEPS];
    logic [SQ_NW-1:0]  r_sn    [2][SQ_STEPS];
    logic [32:0]       r_srem  [2][SQ_STEPS];
    logic [30:0]       r_sroot [2][SQ_STEPS];

    // vectoring cordic
    logic                 r_v_vld [NS];
    logic signed [CW-1:0] r_vx [NS];
    logic signed [CW-1:0] r_vy [NS];
    logic signed [CW-1:0] r_vz [NS];

    // scaling and output
    logic        r_zm_vld;
    logic [56:0] r_zm;
    logic [32:0] w_zc;
    logic [56:0] w_rnd;
    logic        r_o_vld;
    logic [24:0] r_dist;

    assign w_en    = !r_o_vld || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_o_vld;
    assign o_distance = r_dist;

    // ---------------- stage a ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_valid;
        end
        if (w_en) begin
            r_lat_a <= i_lat_a;
            r_lat_b <= i_lat_b;
            r_dlat  <= $signed({i_lat_b[30], i_lat_b}) - $signed({i_lat_a[30], i_lat_a});
            r_dlon  <= $signed({i_lon_b[31], i_lon_b}) - $signed({i_lon_a[31], i_lon_a});
        end
    end

    // ---------------- stage b ----------------
    always_comb begin
        w_pa = r_lat_a * $signed({1'b0, CONV_K});
        w_pb = r_lat_b * $signed({1'b0, CONV_K});
        w_pl = r_dlat * $signed({1'b0, CONV_K});
        w_po = r_dlon * $signed({1'b0, CONV_K});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
        if (w_en) begin
            r_t[0] <= w_pa[61:30];
            r_t[1] <= w_pb[61:30];
            // half angles
            r_t[2] <= w_pl[62:31];
            r_t[3] <= w_po[62:31];
        end
    end

    // ---------------- stage c ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    for (genvar u = 0; u < 4; u++) begin : g_prep
        logic        [31:0] w_tq, w_d, w_neg;
        logic        [1:0]  w_q;
        logic        [29:0] w_mag;
        logic        [61:0] w_pm, w_ps;
        logic        [30:0] w_zm;

        always_comb begin
            w_tq  = r_t[u] + 32'h2000_0000;
            w_q   = w_tq[31:30];
            w_d   = r_t[u] - {w_q, 30'd0};
            w_neg = 32'd0 - w_d;
            w_mag = w_d[31] ? w_neg[29:0] : w_d[29:0];
            w_pm  = w_mag * PI_Q30;
            w_ps  = w_pm + 62'h4000_0000;
            w_zm  = w_ps[61:31];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c_q[u] <= w_q;
                if (w_d[31]) begin
                    r_c_z[u] <= $signed({{(CW-31){1'b0}}, w_zm}) * -1;
                end else begin
                    r_c_z[u] <= $signed({{(CW-31){1'b0}}, w_zm});
                end
            end
        end
    end

    // ---------------- rotation cordic ----------------
    for (genvar k = 0; k < NS; k++) begin : g_rvld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_r_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_r_vld[k] <= (k == 0) ? r_c_vld : r_r_vld[(k == 0) ? 0 : k-1];
            end
        end
    end

    for (genvar u = 0; u < 4; u++) begin : g_rot
        for (genvar k = 0; k < NS; k++) begin : g_stg
            logic signed [CW-1:0] w_x, w_y, w_z, w_at;
            logic        [1:0]    w_q;

            if (k == 0) begin : g_src0
                assign w_x = $signed({{(CW-32){1'b0}}, GAIN_Q30});
                assign w_y = '0;
                assign w_z = r_c_z[u];
                assign w_q = r_c_q[u];
            end else begin : g_srck
                assign w_x = r_rx[u][k-1];
                assign w_y = r_ry[u][k-1];
                assign w_z = r_rz[u][k-1];
                assign w_q = r_rq[u][k-1];
            end
            assign w_at = $signed({{(CW-32){1'b0}}, atan_q30(k)});

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rq[u][k] <= w_q;
                    if (w_z >= 0) begin
                        r_rx[u][k] <= w_x - (w_y >>> k);
                        r_ry[u][k] <= w_y + (w_x >>> k);
                        r_rz[u][k] <= w_z - w_at;
                    end else begin
                        r_rx[u][k] <= w_x + (w_y >>> k);
                        r_ry[u][k] <= w_y - (w_x >>> k);
                        r_rz[u][k] <= w_z + w_at;
                    end
                end
            end
        end
    end

    // ---------------- quadrant correction ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qd_vld <= 1'b0;
        end else if (w_en) begin
            r_qd_vld <= r_r_vld[NS-1];
        end
    end

    for (genvar u = 0; u < 4; u++) begin : g_quad
        logic signed [CW-1:0] w_x, w_y, w_c, w_s;

        always_comb begin
            w_x = r_rx[u][NS-1];
            w_y = r_ry[u][NS-1];
            case (r_rq[u][NS-1])
                2'd0: begin
                    w_c = w_x;
                    w_s = w_y;
                end
                2'd1: begin
                    w_c = -w_y;
                    w_s = w_x;
                end
                2'd2: begin
                    w_c = -w_x;
                    w_s = -w_y;
                end
                default: begin
                    w_c = w_y;
                    w_s = -w_x;
                end
            endcase
        end

        // latitudes need cosines, half differences need sines
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_qv[u] <= (u < 2) ? w_c : w_s;
            end
        end
    end

    // ---------------- products and h ----------------
    always_comb begin
        w_m_ll = r_qv[2] * r_qv[2];
        w_m_ab = r_qv[0] * r_qv[1];
        w_m_oo = r_qv[3] * r_qv[3];
        w_m_2  = r_p_ab * r_p_oo;
        w_h    = r_p_ll2 + r_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_h_vld  <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= r_qd_vld;
            r_p2_vld <= r_p1_vld;
            r_h_vld  <= r_p2_vld;
        end
        if (w_en) begin
            r_p_ll  <= w_m_ll[CW+29:30];
            r_p_ab  <= w_m_ab[CW+29:30];
            r_p_oo  <= w_m_oo[CW+29:30];
            r_p_ll2 <= r_p_ll;
            r_p2    <= w_m_2[CW+29:30];
            // clamp h to [0, 1]
            if (w_h < 0) begin
                r_h <= '0;
            end else if (w_h > LP_ONE) begin
                r_h <= ONE_Q30;
            end else begin
                r_h <= w_h[30:0];
            end
        end
    end

    // ---------------- square roots ----------------
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_svld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_s_vld[k] <= (k == 0) ? r_h_vld : r_s_vld[(k == 0) ? 0 : k-1];
            end
        end
    end

    for (genvar u = 0; u < 2; u++) begin : g_sqrt
        for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stg
            logic [SQ_NW-1:0] w_n;
            logic [32:0]      w_rem;
            logic [30:0]      w_root;
            logic [34:0]      w_tv, w_tr, w_df;

            if (k == 0) begin : g_src0
                if (u == 0) begin : g_hi
                    assign w_n = {1'b0, r_h, 30'd0};
                end else begin : g_lo
                    assign w_n = {1'b0, ONE_Q30 - r_h, 30'd0};
                end
                assign w_rem  = '0;
                assign w_root = '0;
            end else begin : g_srck
                assign w_n    = r_sn[u][k-1];
                assign w_rem  = r_srem[u][k-1];
                assign w_root = r_sroot[u][k-1];
            end

            always_comb begin
                w_tv = {w_rem, w_n[SQ_NW-1:SQ_NW-2]};
                w_tr = {2'b00, w_root, 2'b01};
                w_df = w_tv - w_tr;
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sn[u][k] <= {w_n[SQ_NW-3:0], 2'b00};
                    if (w_tv >= w_tr) begin
                        r_srem[u][k]  <= w_df[32:0];
                        r_sroot[u][k] <= {w_root[29:0], 1'b1};
                    end else begin
                        r_srem[u][k]  <= w_tv[32:0];
                        r_sroot[u][k] <= {w_root[29:0], 1'b0};
                    end
                end
            end
        end
    end

    // vectoring cordic: atan2(s0, s1)
    for (genvar k = 0; k < NS; k++) begin : g_vec
        logic signed [CW-1:0] w_x, w_y, w_z, w_at;
        logic                 w_v;

        if (k == 0) begin : g_src0
            assign w_x = $signed({{(CW-31){1'b0}}, r_sroot[1][SQ_STEPS-1]});
            assign w_y = $signed({{(CW-31){1'b0}}, r_sroot[0][SQ_STEPS-1]});
            assign w_z = '0;
            assign w_v = r_s_vld[SQ_STEPS-1];
        end else begin : g_srck
            assign w_x = r_vx[k-1];
            assign w_y = r_vy[k-1];
            assign w_z = r_vz[k-1];
            assign w_v = r_v_vld[k-1];
        end
        assign w_at = $signed({{(CW-32){1'b0}}, atan_q30(k)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_v_vld[k] <= w_v;
            end
            if (w_en) begin
                if (w_y >= 0) begin
                    r_vx[k] <= w_x + (w_y >>> k);
                    r_vy[k] <= w_y - (w_x >>> k);
                    r_vz[k] <= w_z + w_at;
                end else begin
                    r_vx[k] <= w_x - (w_y >>> k);
                    r_vy[k] <= w_y + (w_x >>> k);
                    r_vz[k] <= w_z - w_at;
                end
            end
        end
    end

    // ---------------- scale to 1/1024 km ----------------
    always_comb begin
        w_zc  = r_vz[NS-1][CW-1] ? 33'd0 : r_vz[NS-1][32:0];
        w_rnd = r_zm + 57'h2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zm_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_zm_vld <= r_v_vld[NS-1];
            r_o_vld  <= r_zm_vld;
        end
        if (w_en) begin
            r_zm   <= w_zc * DIST_SCALE;
            r_dist <= w_rnd[54:30];
        end
    end

    `HVD_ASSERT_NR(a_rst_clears_out, i_clk, !i_rst_n |=> !o_valid)
    `HVD_ASSERT(a_h_clamped, i_clk, i_rst_n, r_h_vld |-> (r_h <= ONE_Q30))
    `HVD_ASSERT(a_stall_holds_mid, i_clk, i_rst_n, o_stall |=> $stable(r_h) && $stable(r_h_vld))
    `HVD_ASSERT(a_last_to_out, i_clk, i_rst_n, (r_zm_vld && !o_stall) |=> o_valid)

endmodule
